// ===== design/evbtsp_pkg.sv =====
`default_nettype none
package evbtsp_pkg;

    // Default number of fractional bits of coordinates and energies
    localparam int FRAC_BITS_DEF = 16;

    // Port widths
    localparam int IN_W  = 24;
    localparam int OUT_W = 48;

    // Internal widths, sized for the widest fractional format (24 bits)
    localparam int RW  = 30;          // root and well-difference magnitude
    localparam int DW  = 2 * RW;      // discriminant
    localparam int DSW = 27;          // signed distance to a well center
    localparam int SQW = 2 * DSW;     // squared distance
    localparam int SW  = 64;          // well-energy sums, Q.2F

    // Number of EVB surfaces evaluated in parallel
    localparam int NSURF = 3;

    // Surface lanes
    localparam int SURF_A = 0;        // H0, 2D part
    localparam int SURF_B = 1;        // H0, 1D part in y
    localparam int SURF_C = 2;        // H1

endpackage
`default_nettype wire

// ===== design/evb_two_surface_potential_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    x_pos, y_pos (24-bit signed Q.F)
// output    out        out_valid / out_ready  energy_h0, energy_h1 (48-bit signed Q.F)
//
// One item enters per cycle while the output is not stalled. A result passes
// through RW + 6 = 36 register stages, most of them the bit-per-stage square-root
// pipeline (one root bit per stage, three lanes).
// rst_n clears only the stage valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; in_ready drops only then,
// so no item is lost or repeated.
module evb_two_surface_potential_unit #(
    parameter int FRAC_BITS = evbtsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [evbtsp_pkg::IN_W-1:0]    x_pos,
    input  wire logic signed [evbtsp_pkg::IN_W-1:0]    y_pos,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [evbtsp_pkg::OUT_W-1:0]        energy_h0,
    output logic signed [evbtsp_pkg::OUT_W-1:0]        energy_h1
);

    localparam int IN_W  = evbtsp_pkg::IN_W;
    localparam int OUT_W = evbtsp_pkg::OUT_W;
    localparam int RW    = evbtsp_pkg::RW;
    localparam int DW    = evbtsp_pkg::DW;
    localparam int DSW   = evbtsp_pkg::DSW;
    localparam int SQW   = evbtsp_pkg::SQW;
    localparam int SW    = evbtsp_pkg::SW;
    localparam int NS    = evbtsp_pkg::NSURF;
    localparam int SA    = evbtsp_pkg::SURF_A;
    localparam int SB    = evbtsp_pkg::SURF_B;
    localparam int SC    = evbtsp_pkg::SURF_C;

    // Stage map: 0 input, 1 distances, 2 squares, 3 discriminant,
    // 4..RW+3 root bits, RW+4 surface energies, RW+5 output
    localparam int NST  = RW + 6;
    localparam int LAST = NST - 1;

    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] OUT_MAX = SW'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX - SW'(1);

    // 4*H12 in Q.2F for each surface
    localparam logic [DW-1:0] CPL_A = DW'(20) << (2 * FRAC_BITS);
    localparam logic [DW-1:0] CPL_B = DW'(40) << (2 * FRAC_BITS);
    localparam logic [DW-1:0] CPL_C = DW'(60) << (2 * FRAC_BITS);
    localparam logic signed [SW-1:0] DELTA_C = SW'(10) <<< (2 * FRAC_BITS);

    logic en;
    logic [NST-1:0] vld_reg;

    // Stage 0
    logic signed [IN_W-1:0] x_reg, y_reg;

    // Stage 1
    logic [RW-1:0]          mag_reg [NS];
    logic signed [DSW-1:0]  dxa_reg, dxb_reg, dxc_reg, dym_reg, dyp_reg;
    logic [RW-1:0]          mag_next [NS];
    logic signed [DSW-1:0]  dxa_next, dxb_next, dxc_next, dym_next, dyp_next;

    // Stage 2
    logic [DW-1:0]          msq_reg [NS];
    logic signed [SQW-1:0]  qxa_reg, qxb_reg, qxc_reg, qym_reg, qyp_reg;

    // Stage 3 onward: root pipeline
    logic [DW-1:0]          rad_reg  [NS][RW+1];
    logic [RW+1:0]          rem_reg  [NS][RW+1];
    logic [RW-1:0]          root_reg [NS][RW+1];
    logic signed [SW-1:0]   sum_reg  [NS][RW+1];
    logic [DW-1:0]          rad_next  [NS][RW];
    logic [RW+1:0]          rem_next  [NS][RW];
    logic [RW-1:0]          root_next [NS][RW];

    // Surface energies and output
    logic signed [SW-1:0]   surf_reg [NS];
    logic signed [SW-1:0]   surf_next [NS];
    logic signed [SW-1:0]   h0_sum, h1_sum;
    logic signed [OUT_W-1:0] h0_reg, h1_reg, h0_next, h1_next;

    // Advance everything unless the output item is held
    assign en       = !vld_reg[LAST] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Distances to well centers and well-difference magnitudes
    always_comb
    begin
        logic signed [SW-1:0] xe, ye, da, db, dc;
        xe = SW'(x_reg);
        ye = SW'(y_reg);
        da = 22 * xe + 11 * HALF;
        db = 36 * ye - 18 * ONE;
        dc = 20 * xe - 10 * ONE;
        mag_next[SA] = RW'(da < 0 ? -da : da);
        mag_next[SB] = RW'(db < 0 ? -db : db);
        mag_next[SC] = RW'(dc < 0 ? -dc : dc);
        dxa_next = DSW'(xe + 3 * ONE);
        dxb_next = DSW'(xe - 5 * HALF);
        dxc_next = DSW'(xe + 5 * HALF);
        dym_next = DSW'(ye + ONE);
        dyp_next = DSW'(ye - 2 * ONE);
    end

    // Root steps: one result bit per stage and lane
    always_comb
    begin
        logic [RW+3:0] trial, sub;
        for (int u = 0; u < NS; u++)
        begin
            for (int k = 0; k < RW; k++)
            begin
                trial = {rem_reg[u][k], rad_reg[u][k][DW-1:DW-2]};
                sub   = (RW+4)'({root_reg[u][k], 2'b01});
                if (trial >= sub)
                begin
                    rem_next[u][k]  = (RW+2)'(trial - sub);
                    root_next[u][k] = {root_reg[u][k][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[u][k]  = (RW+2)'(trial);
                    root_next[u][k] = {root_reg[u][k][RW-2:0], 1'b0};
                end
                rad_next[u][k] = {rad_reg[u][k][DW-3:0], 2'b00};
            end
        end
    end

    // Combine wells and roots, round toward minus infinity, then sum and saturate to the output width
    always_comb
    begin
        logic signed [SW-1:0] w;
        for (int u = 0; u < NS; u++)
        begin
            w = sum_reg[u][RW] - (SW'(root_reg[u][RW]) <<< FRAC_BITS);
            surf_next[u] = w >>> (FRAC_BITS + 1);
        end
        h0_sum = surf_reg[SA] + surf_reg[SB];
        h1_sum = surf_reg[SC];
        if (h0_sum > OUT_MAX)
            h0_next = OUT_W'(OUT_MAX);
        else if (h0_sum < OUT_MIN)
            h0_next = OUT_W'(OUT_MIN);
        else
            h0_next = OUT_W'(h0_sum);
        if (h1_sum > OUT_MAX)
            h1_next = OUT_W'(OUT_MAX);
        else if (h1_sum < OUT_MIN)
            h1_next = OUT_W'(OUT_MIN);
        else
            h1_next = OUT_W'(h1_sum);
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_pos;
            y_reg <= y_pos;

            for (int u = 0; u < NS; u++)
                mag_reg[u] <= mag_next[u];
            dxa_reg <= dxa_next;
            dxb_reg <= dxb_next;
            dxc_reg <= dxc_next;
            dym_reg <= dym_next;
            dyp_reg <= dyp_next;

            for (int u = 0; u < NS; u++)
                msq_reg[u] <= DW'(mag_reg[u]) * DW'(mag_reg[u]);
            qxa_reg <= SQW'(dxa_reg) * SQW'(dxa_reg);
            qxb_reg <= SQW'(dxb_reg) * SQW'(dxb_reg);
            qxc_reg <= SQW'(dxc_reg) * SQW'(dxc_reg);
            qym_reg <= SQW'(dym_reg) * SQW'(dym_reg);
            qyp_reg <= SQW'(dyp_reg) * SQW'(dyp_reg);

            rad_reg[SA][0] <= msq_reg[SA] + CPL_A;
            rad_reg[SB][0] <= msq_reg[SB] + CPL_B;
            rad_reg[SC][0] <= msq_reg[SC] + CPL_C;
            sum_reg[SA][0] <= 2 * SW'(qxa_reg) + 2 * SW'(qxb_reg) + 4 * SW'(qym_reg);
            sum_reg[SB][0] <= 6 * SW'(qym_reg) + 6 * SW'(qyp_reg);
            sum_reg[SC][0] <= 2 * SW'(qxc_reg) + 2 * SW'(qxb_reg) + 4 * SW'(qyp_reg)
                              + DELTA_C;
            for (int u = 0; u < NS; u++)
            begin
                rem_reg[u][0]  <= '0;
                root_reg[u][0] <= '0;
                for (int k = 0; k < RW; k++)
                begin
                    rad_reg[u][k+1]  <= rad_next[u][k];
                    rem_reg[u][k+1]  <= rem_next[u][k];
                    root_reg[u][k+1] <= root_next[u][k];
                    sum_reg[u][k+1]  <= sum_reg[u][k];
                end
                surf_reg[u] <= surf_next[u];
            end

            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end

    assign out_valid = vld_reg[LAST];
    assign energy_h0 = h0_reg;
    assign energy_h1 = h1_reg;

endmodule
`default_nettype wire
